// ----- design/necir_pkg.sv -----
// ----------------------------------------------------------------------------
// necir_pkg
// Shared constants, types and helpers for the NEC infrared frame decoder.
// ----------------------------------------------------------------------------
package necir_pkg;

    // width of the duration fields on the ports
    localparam int FIELD_W = 16;
    // durations are saturated to this many bits before matching
    localparam int DURATION_WIDTH = 16;
    localparam logic [31:0] DURATION_MAX = 32'((64'd1 << DURATION_WIDTH) - 64'd1);

    // durations are compared after scaling by 100, so windows need 7 more bits
    localparam int SCALED_W = FIELD_W + 7;

    localparam int TOL_W  = 6;
    localparam int DATA_W = 16;
    localparam int INDEX_W = 2;
    localparam int STATUS_W = 2;

    // configuration register indexes
    localparam logic [INDEX_W-1:0] REG_TOLERANCE = 2'd0;
    localparam logic [INDEX_W-1:0] REG_EXP_ADDR  = 2'd1;
    localparam logic [INDEX_W-1:0] REG_EXP_CMD   = 2'd2;

    localparam logic [TOL_W-1:0] TOL_RESET = 6'd25;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_HEADER = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_BIT    = 2'd2;

    // nominal durations in microseconds
    localparam logic [13:0] NOM_HDR_MARK  = 14'd9000;
    localparam logic [13:0] NOM_HDR_SPACE = 14'd4500;
    localparam logic [13:0] NOM_SHORT     = 14'd560;
    localparam logic [13:0] NOM_LONG      = 14'd1690;

    // acceptance window, both bounds scaled by 100
    typedef struct packed {
        logic [SCALED_W-1:0] lo;
        logic [SCALED_W-1:0] hi;
    } window_t;

    typedef struct packed {
        window_t hdr_mark;
        window_t hdr_space;
        window_t short_pulse;
        window_t long_pulse;
    } windows_t;

    typedef struct packed {
        logic hdr_ok;
        logic one_ok;
        logic zero_ok;
    } pair_match_t;

    function automatic window_t make_window(input logic [13:0] nominal,
                                            input logic [TOL_W-1:0] tol);
        logic [7:0] lower;
        logic [7:0] upper;
        window_t    w;
        lower = 8'd100 - {2'b00, tol};
        upper = 8'd100 + {2'b00, tol};
        w.lo  = SCALED_W'(nominal) * SCALED_W'(lower);
        w.hi  = SCALED_W'(nominal) * SCALED_W'(upper);
        return w;
    endfunction

    function automatic windows_t make_windows(input logic [TOL_W-1:0] tol);
        windows_t ws;
        ws.hdr_mark    = make_window(NOM_HDR_MARK, tol);
        ws.hdr_space   = make_window(NOM_HDR_SPACE, tol);
        ws.short_pulse = make_window(NOM_SHORT, tol);
        ws.long_pulse  = make_window(NOM_LONG, tol);
        return ws;
    endfunction

endpackage

// ----- design/nec_ir_frame_decoder.sv -----
// ----------------------------------------------------------------------------
// nec_ir_frame_decoder
// Decodes NEC infrared frames from measured mark/space duration pairs.
// ----------------------------------------------------------------------------
// Input beats (s_*) carry one mark/space pair each, with s_burst_start set on
// the first pair of a burst, which must be the 9000/4500 us header. The next
// 32 pairs are data bits, MSB first; the 32nd gives one result beat (m_*) with
// address, command and the match flag. A bad header or bad bit gives an error
// beat and the decoder ignores pairs until the next burst start.
// Configuration goes through cfg_we/cfg_index/cfg_wdata while no frame is in
// flight; the tolerance write recomputes the scaled windows in the same edge.
// A pair waits in the input register until the result slot is free or emptied,
// then any result it gives is loaded into the result register. Throughput: one
// pair per cycle while results are taken, set by the single decode stage in between.
// If the receiver stalls, one result waits in the output register while the
// next pair is still taken into the input register; s_ready then drops.
// Reset returns tolerance to 25 percent, expected address and command to 0,
// and the decoder to waiting for a burst start with no beats held.
module nec_ir_frame_decoder (
    input  logic                            aclk,
    input  logic                            aresetn,

    input  logic                            cfg_we,
    input  logic [necir_pkg::INDEX_W-1:0]   cfg_index,
    input  logic [necir_pkg::DATA_W-1:0]    cfg_wdata,

    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_burst_start,
    input  logic [necir_pkg::FIELD_W-1:0]   s_mark_us,
    input  logic [necir_pkg::FIELD_W-1:0]   s_space_us,

    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [necir_pkg::STATUS_W-1:0]  m_status,
    output logic [15:0]                     m_address,
    output logic [15:0]                     m_command,
    output logic                            m_matched
);

    localparam logic PH_WAIT = 1'b0;
    localparam logic PH_BITS = 1'b1;

    // configuration
    necir_pkg::windows_t windows_reg;
    logic [15:0]         exp_addr_reg;
    logic [15:0]         exp_cmd_reg;

    // input register
    logic                           in_vld_reg;
    logic                           in_start_reg;
    logic [necir_pkg::FIELD_W-1:0]  in_mark_reg;
    logic [necir_pkg::FIELD_W-1:0]  in_space_reg;

    // decode state
    logic        phase_reg, phase_next;
    logic [4:0]  bit_cnt_reg, bit_cnt_next;
    logic [31:0] frame_reg, frame_next;

    // result register
    logic                           out_vld_reg;
    logic [necir_pkg::STATUS_W-1:0] out_status_reg, out_status_next;
    logic [15:0]                    out_addr_reg, out_addr_next;
    logic [15:0]                    out_cmd_reg, out_cmd_next;
    logic                           out_match_reg, out_match_next;
    logic                           res_vld;

    necir_pkg::pair_match_t pair_match;
    logic                   advance;
    logic                   bit_val;

    necir_classify u_classify (
        .mark_us    (in_mark_reg),
        .space_us   (in_space_reg),
        .windows    (windows_reg),
        .pair_match (pair_match)
    );

    // the input beat moves on whenever the result slot is free or being emptied
    assign advance = in_vld_reg && (!out_vld_reg || m_ready);
    assign s_ready = !in_vld_reg || advance;

    assign m_valid   = out_vld_reg;
    assign m_status  = out_status_reg;
    assign m_address = out_addr_reg;
    assign m_command = out_cmd_reg;
    assign m_matched = out_match_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            windows_reg  <= necir_pkg::make_windows(necir_pkg::TOL_RESET);
            exp_addr_reg <= '0;
            exp_cmd_reg  <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                necir_pkg::REG_TOLERANCE: begin
                    windows_reg <= necir_pkg::make_windows(cfg_wdata[necir_pkg::TOL_W-1:0]);
                end
                necir_pkg::REG_EXP_ADDR: begin
                    exp_addr_reg <= cfg_wdata[15:0];
                end
                necir_pkg::REG_EXP_CMD: begin
                    exp_cmd_reg <= cfg_wdata[15:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        phase_next      = phase_reg;
        bit_cnt_next    = bit_cnt_reg;
        frame_next      = frame_reg;
        res_vld         = 1'b0;
        out_status_next = necir_pkg::ST_OK;
        out_addr_next   = '0;
        out_cmd_next    = '0;
        out_match_next  = 1'b0;
        bit_val         = pair_match.one_ok;

        if (in_start_reg) begin
            bit_cnt_next = '0;
            frame_next   = '0;
            if (pair_match.hdr_ok) begin
                phase_next = PH_BITS;
            end else begin
                phase_next      = PH_WAIT;
                res_vld         = 1'b1;
                out_status_next = necir_pkg::ST_BAD_HEADER;
            end
        end else if (phase_reg == PH_BITS) begin
            if (pair_match.one_ok || pair_match.zero_ok) begin
                frame_next = {frame_reg[30:0], bit_val};
                if (bit_cnt_reg == 5'd31) begin
                    phase_next     = PH_WAIT;
                    bit_cnt_next   = '0;
                    res_vld        = 1'b1;
                    out_addr_next  = frame_next[31:16];
                    out_cmd_next   = frame_next[15:0];
                    out_match_next = (frame_next[31:16] == exp_addr_reg)
                                  && (frame_next[15:0] == exp_cmd_reg);
                end else begin
                    bit_cnt_next = bit_cnt_reg + 5'd1;
                end
            end else begin
                phase_next      = PH_WAIT;
                bit_cnt_next    = '0;
                res_vld         = 1'b1;
                out_status_next = necir_pkg::ST_BAD_BIT;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            phase_reg   <= PH_WAIT;
            bit_cnt_reg <= '0;
            frame_reg   <= '0;
        end else begin
            if (s_valid && s_ready) begin
                in_vld_reg <= 1'b1;
            end else if (advance) begin
                in_vld_reg <= 1'b0;
            end

            if (advance) begin
                phase_reg   <= phase_next;
                bit_cnt_reg <= bit_cnt_next;
                frame_reg   <= frame_next;
            end

            if (advance && res_vld) begin
                out_vld_reg <= 1'b1;
            end else if (m_ready) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_start_reg <= s_burst_start;
            in_mark_reg  <= s_mark_us;
            in_space_reg <= s_space_us;
        end
        if (advance && res_vld) begin
            out_status_reg <= out_status_next;
            out_addr_reg   <= out_addr_next;
            out_cmd_reg    <= out_cmd_next;
            out_match_reg  <= out_match_next;
        end
    end

endmodule

// ----- design/necir_classify.sv -----
// ----------------------------------------------------------------------------
// necir_classify
// Matches one mark/space pair against the header and data bit windows.
// ----------------------------------------------------------------------------
module necir_classify (
    input  logic [necir_pkg::FIELD_W-1:0] mark_us,
    input  logic [necir_pkg::FIELD_W-1:0] space_us,
    input  necir_pkg::windows_t           windows,
    output necir_pkg::pair_match_t        pair_match
);

    logic [necir_pkg::FIELD_W-1:0]  mark_clip;
    logic [necir_pkg::FIELD_W-1:0]  space_clip;
    logic [necir_pkg::SCALED_W-1:0] mark_scaled;
    logic [necir_pkg::SCALED_W-1:0] space_scaled;
    logic                           hdr_mark_ok;
    logic                           hdr_space_ok;
    logic                           short_mark_ok;
    logic                           short_space_ok;
    logic                           long_space_ok;

    function automatic logic in_window(input logic [necir_pkg::SCALED_W-1:0] scaled,
                                       input necir_pkg::window_t w);
        // floor(lo/100) <= d  <=>  lo <= 100d + 99 ; d <= floor(hi/100)  <=>  100d <= hi
        return ((scaled + necir_pkg::SCALED_W'(99)) >= w.lo) && (scaled <= w.hi);
    endfunction

    always_comb begin
        mark_clip  = (32'(mark_us) > necir_pkg::DURATION_MAX)
                   ? necir_pkg::FIELD_W'(necir_pkg::DURATION_MAX) : mark_us;
        space_clip = (32'(space_us) > necir_pkg::DURATION_MAX)
                   ? necir_pkg::FIELD_W'(necir_pkg::DURATION_MAX) : space_us;
        mark_scaled  = necir_pkg::SCALED_W'(mark_clip) * necir_pkg::SCALED_W'(100);
        space_scaled = necir_pkg::SCALED_W'(space_clip) * necir_pkg::SCALED_W'(100);

        hdr_mark_ok    = in_window(mark_scaled, windows.hdr_mark);
        hdr_space_ok   = in_window(space_scaled, windows.hdr_space);
        short_mark_ok  = in_window(mark_scaled, windows.short_pulse);
        short_space_ok = in_window(space_scaled, windows.short_pulse);
        long_space_ok  = in_window(space_scaled, windows.long_pulse);

        pair_match.hdr_ok  = hdr_mark_ok && hdr_space_ok;
        pair_match.one_ok  = short_mark_ok && long_space_ok;
        pair_match.zero_ok = short_mark_ok && short_space_ok;
    end

endmodule
